// File: rtl/core/gf2_bit_matrix_block_mac_defines.svh
// assertion macros for the gf2 bit-matrix block mac
// no dependencies; included by files that carry concurrent checks
`ifndef GF2_BIT_MATRIX_BLOCK_MAC_DEFINES_SVH
`define GF2_BIT_MATRIX_BLOCK_MAC_DEFINES_SVH

`ifndef SYNTHESIS
// implication or plain property, checked on the rising clock edge outside reset
`define GF2BM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// expression that must never be true outside reset
`define GF2BM_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define GF2BM_ASSERT(lbl, clk, rst, prop, msg)
`define GF2BM_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// File: rtl/core/gf2bm_pkg.sv
// shared types and constants for the gf2 bit-matrix block mac
// no dependencies
`timescale 1ns / 1ps
package gf2bm_pkg;

  localparam int BLOCK_W = 64;
  localparam int TDATA_W = 2 * BLOCK_W;

  // delta-swap masks for the 8x8 transpose
  localparam logic [BLOCK_W-1:0] SWAP4_MASK = 64'hf0f0_f0f0_0000_0000;
  localparam logic [BLOCK_W-1:0] SWAP2_MASK = 64'hcccc_0000_cccc_0000;
  localparam logic [BLOCK_W-1:0] SWAP1_MASK = 64'haa00_aa00_aa00_aa00;

  typedef enum logic [1:0] {
    REQ_MUL       = 2'd0,
    REQ_MUL_T     = 2'd1,
    REQ_TRANSPOSE = 2'd2
  } req_type_t;

endpackage

// File: rtl/core/gf2_bit_matrix_block_mac.sv
// an accepted item is registered in the input reg, and the input reg feeds the result reg on a last item
// throughput: one item per cycle; the only stall is a last item meeting an unread result
// the path between the two registers is the 64-bit and/xor/parity network of gf2bm_ops plus the xor accumulator
// reset (rst, synchronous, active high) clears both valid flags and the accumulator
// depends on gf2bm_pkg, gf2bm_ops and gf2_bit_matrix_block_mac_defines.svh
`timescale 1ns / 1ps
`include "gf2_bit_matrix_block_mac_defines.svh"
module gf2_bit_matrix_block_mac import gf2bm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // input item stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [TDATA_W-1:0] s_axis_tdata,  // a_block [63:0], b_block [127:64]
  input  logic [1:0]         s_axis_tuser,  // req_type [1:0]
  input  logic               s_axis_tlast,  // last_block
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [BLOCK_W-1:0] m_axis_tdata   // result_block [63:0]
);

  // input register stage
  logic               s1_valid;
  req_type_t          s1_type;
  logic [BLOCK_W-1:0] s1_a;
  logic [BLOCK_W-1:0] s1_b;
  logic               s1_last;

  // running xor sum of the current dot product
  logic [BLOCK_W-1:0] partial_sum;
  logic [BLOCK_W-1:0] partial_sum_next;

  logic [BLOCK_W-1:0] op_val;
  logic               s1_adv;
  logic               s1_emit;

  // a non-last item never needs the output register, so it always moves on;
  // a last item waits only while an earlier result is still unread
  assign s1_adv        = !s1_last || !m_axis_tvalid || m_axis_tready;
  assign s1_emit       = s1_valid && s1_last && s1_adv;
  assign s_axis_tready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_type <= req_type_t'(s_axis_tuser);
      s1_a    <= s_axis_tdata[BLOCK_W-1:0];
      s1_b    <= s_axis_tdata[TDATA_W-1:BLOCK_W];
      s1_last <= s_axis_tlast;
    end
  end

  gf2bm_ops u_ops (
    .req_type (s1_type),
    .a_block  (s1_a),
    .b_block  (s1_b),
    .op_val   (op_val)
  );

  assign partial_sum_next = partial_sum ^ op_val;

  // accumulate, clear on the last item of a dot product
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_sum <= '0;
    end else if (s1_valid && s1_adv) begin
      partial_sum <= s1_last ? '0 : partial_sum_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_emit) begin
      m_axis_tdata <= partial_sum_next;
    end
  end

  // checks
  `GF2BM_ASSERT(a_emit_valid, clk, rst, s1_emit |=> m_axis_tvalid, "emit did not raise result valid")
  `GF2BM_ASSERT(a_emit_clear, clk, rst, s1_emit |=> (partial_sum == '0), "sum not cleared on emit")
  `GF2BM_ASSERT_NEVER(a_stall_cause, clk, rst, !s_axis_tready && !(s1_valid && s1_last && m_axis_tvalid && !m_axis_tready), "input stalled without a blocked result")

endmodule

// File: rtl/core/gf2bm_ops.sv
// combinational 8x8 gf2 matrix operations: a*b, a*b^t, a^t
// depends on gf2bm_pkg
`timescale 1ns / 1ps
module gf2bm_ops import gf2bm_pkg::*; (
  input  req_type_t          req_type,
  input  logic [BLOCK_W-1:0] a_block,
  input  logic [BLOCK_W-1:0] b_block,
  output logic [BLOCK_W-1:0] op_val
);

  logic [BLOCK_W-1:0] mul_val;
  logic [BLOCK_W-1:0] mul_t_val;
  logic [BLOCK_W-1:0] tr_val;
  logic [BLOCK_W-1:0] tr_d;
  logic [BLOCK_W-1:0] tr_m1;
  logic [BLOCK_W-1:0] tr_m2;

  // a*b: row j, col c = xor over k of a[j][k] & b[7-k][c]
  // a*b^t: row j, col c = parity(a row j & b byte 7-c)
  always_comb begin
    mul_val   = '0;
    mul_t_val = '0;
    for (int j = 0; j < 8; j++) begin
      for (int c = 0; c < 8; c++) begin
        for (int k = 0; k < 8; k++) begin
          mul_val[8*j+c] = mul_val[8*j+c] ^ (a_block[8*j+k] & b_block[8*(7-k)+c]);
        end
        mul_t_val[8*j+c] = ^(a_block[8*j +: 8] & b_block[8*(7-c) +: 8]);
      end
    end
  end

  // transpose by three delta swaps
  always_comb begin
    tr_d   = (a_block ^ (a_block << 36)) & SWAP4_MASK;
    tr_m1  = a_block ^ tr_d ^ (tr_d >> 36);
    tr_d   = (tr_m1 ^ (tr_m1 << 18)) & SWAP2_MASK;
    tr_m2  = tr_m1 ^ tr_d ^ (tr_d >> 18);
    tr_d   = (tr_m2 ^ (tr_m2 << 9)) & SWAP1_MASK;
    tr_val = tr_m2 ^ tr_d ^ (tr_d >> 9);
  end

  always_comb begin
    case (req_type)
      REQ_MUL:       op_val = mul_val;
      REQ_MUL_T:     op_val = mul_t_val;
      REQ_TRANSPOSE: op_val = tr_val;
      default:       op_val = '0;
    endcase
  end

endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the gf2 bit-matrix block mac: directed and random block dot products
// depends on gf2bm_pkg and the gf2_bit_matrix_block_mac rtl
`timescale 1ns / 1ps
module testbench;
  import gf2bm_pkg::*;

  // selector value that names no operation and contributes zero
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [BLOCK_W-1:0] ALL_ONES = '1;
  localparam logic [BLOCK_W-1:0] IDENTITY = 64'h0102_0408_1020_4080;
  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT = 200_000;

  // running xor of block products and the dot-product sums still owed by the block
  class block_sum_board;
    logic [BLOCK_W-1:0] running_sum;
    logic [BLOCK_W-1:0] pending_sums[$];
    int unsigned failures;

    function new();
      running_sum = '0;
      failures = 0;
    endfunction

    // value of one block operation
    function logic [BLOCK_W-1:0] block_product(logic [1:0] req, logic [BLOCK_W-1:0] a,
                                               logic [BLOCK_W-1:0] b);
      logic [BLOCK_W-1:0] val;
      val = '0;
      case (req)
        REQ_MUL: begin
          // row in byte j picks the b rows named by its set bits
          for (int j = 0; j < 8; j++)
            for (int k = 0; k < 8; k++)
              if (a[8*j+k]) val[8*j +: 8] ^= b[8*(7-k) +: 8];
        end
        REQ_MUL_T: begin
          for (int j = 0; j < 8; j++)
            for (int c = 0; c < 8; c++)
              val[8*j+c] = ^(a[8*j +: 8] & b[8*(7-c) +: 8]);
        end
        REQ_TRANSPOSE: begin
          // row r, column c takes row c, column r
          for (int r = 0; r < 8; r++)
            for (int c = 0; c < 8; c++)
              val[8*(7-r)+c] = a[8*(7-c)+r];
        end
        default: val = '0;
      endcase
      return val;
    endfunction

    function void note_block(logic [1:0] req, logic [BLOCK_W-1:0] a, logic [BLOCK_W-1:0] b,
                             logic last);
      running_sum ^= block_product(req, a, b);
      if (last) begin
        pending_sums.push_back(running_sum);
        running_sum = '0;
      end
    endfunction

    function void check_sum(logic [BLOCK_W-1:0] actual);
      logic [BLOCK_W-1:0] expected;
      if (pending_sums.size() == 0) begin
        $error("result_block: expected no item, got %h", actual);
        failures++;
      end else begin
        expected = pending_sums.pop_front();
        if (actual !== expected) begin
          $error("result_block: expected %h, got %h", expected, actual);
          failures++;
        end
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;  // a_block [63:0], b_block [127:64]
  logic [1:0]         s_axis_tuser = '0;  // req_type [1:0]
  logic               s_axis_tlast = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [BLOCK_W-1:0] m_axis_tdata;       // result_block [63:0]

  block_sum_board board = new();
  bit steady_flow = 1'b0;  // both sides run without gaps while set
  int items_sent = 0;
  int unsigned cycle_count = 0;

  gf2_bit_matrix_block_mac uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk = ~clk;

  // hard stop for a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [BLOCK_W-1:0] rand_matrix();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ALL_ONES;
      2: return 64'd1 << $urandom_range(0, 63);
      3: return IDENTITY;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // offer one item after a random gap, return at the edge that takes it
  task automatic send_block(input logic [1:0] req, input logic [BLOCK_W-1:0] a,
                            input logic [BLOCK_W-1:0] b, input logic last);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    s_axis_tuser  <= req;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    board.note_block(req, a, b, last);
    items_sent++;
  endtask

  // hold off the sender until every owed sum has come out
  task automatic drain_sums();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending_sums.size() != 0);
  endtask

  // one dot product of random length with random operations
  task automatic random_dot_product();
    int len;
    logic [1:0] req;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      req = ($urandom_range(0, 15) == 0) ? REQ_UNUSED : 2'($urandom_range(0, 2));
      send_block(req, rand_matrix(), rand_matrix(), i == len - 1);
    end
  endtask

  // result side: random stall before each item
  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      board.check_sum(m_axis_tdata);
    end
  end

  initial begin
    logic [BLOCK_W-1:0] x, y;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes of each operation, back to back
    steady_flow = 1'b1;
    send_block(REQ_MUL, '0, '0, 1'b1);
    send_block(REQ_MUL, ALL_ONES, ALL_ONES, 1'b1);
    send_block(REQ_MUL, IDENTITY, {$urandom, $urandom}, 1'b1);
    send_block(REQ_MUL, {$urandom, $urandom}, IDENTITY, 1'b1);
    send_block(REQ_MUL_T, ALL_ONES, ALL_ONES, 1'b1);
    send_block(REQ_MUL_T, IDENTITY, {$urandom, $urandom}, 1'b1);
    send_block(REQ_MUL_T, 64'd1, 64'h8000_0000_0000_0000, 1'b1);
    send_block(REQ_TRANSPOSE, 64'haaaa_aaaa_aaaa_aaaa, ALL_ONES, 1'b1);
    send_block(REQ_TRANSPOSE, 64'h8000_0000_0000_0001, '0, 1'b1);
    send_block(REQ_TRANSPOSE, 64'h5555_5555_5555_5555, ALL_ONES, 1'b1);
    // unused selector alone and closing an accumulation
    send_block(REQ_UNUSED, ALL_ONES, ALL_ONES, 1'b1);
    send_block(REQ_MUL, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
    send_block(REQ_MUL_T, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
    send_block(REQ_TRANSPOSE, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
    send_block(REQ_UNUSED, ALL_ONES, ALL_ONES, 1'b1);
    // the same product twice cancels to zero
    x = {$urandom, $urandom};
    y = {$urandom, $urandom};
    send_block(REQ_MUL, x, y, 1'b0);
    send_block(REQ_MUL, x, y, 1'b1);
    // short run with gaps on both sides
    steady_flow = 1'b0;
    send_block(REQ_MUL_T, x, y, 1'b0);
    send_block(REQ_TRANSPOSE, y, x, 1'b0);
    send_block(REQ_MUL, y, x, 1'b1);
    drain_sums();

    // random dot products with stretches of steady flow
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      steady_flow = ($urandom_range(0, 4) == 0);
      random_dot_product();
      if ($urandom_range(0, 40) == 0) drain_sums();
    end

    s_axis_tvalid <= 1'b0;
    while (board.pending_sums.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.failures == 0 && board.pending_sums.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
